/* sv/rpn_pkg.sv */
// Package with the request and result types, codes and sizes of the RPN stack evaluator.
`timescale 1ns / 1ps
package rpn_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned Depth     = 64;
  localparam int unsigned AddrWidth = $clog2(Depth);
  localparam int unsigned CountWidth = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    OpNum = 3'd0,
    OpAdd = 3'd1,
    OpSub = 3'd2,
    OpMul = 3'd3,
    OpDiv = 3'd4,
    OpUnk = 3'd5,
    OpEnd = 3'd6,
    OpBad = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StMalformed = 3'd1,
    StFlow     = 3'd2,
    StDivZero  = 3'd3,
    StWrongOp  = 3'd4,
    StBadFirst = 3'd5,
    StEmpty    = 3'd6,
    StRsvd     = 3'd7
  } status_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } res_t;

endpackage

/* sv/rpn_ram.sv */
// Single-port-write, dual-read synchronous stack memory with registered read data.
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Words = 64,
  parameter int unsigned AddrW = $clog2(Words)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Words];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* sv/rpn_div.sv */
// Serial signed divider that truncates toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps
module rpn_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] q_o
);
  import rpn_pkg::*;

  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d, run_q, run_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    run_d   = run_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    shifted = {rem_q[30:0], quo_q[31]};
    trial   = {1'b0, shifted} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = a_i[31] ? (32'd0 - a_i) : a_i;
      den_d = b_i[31] ? (32'd0 - b_i) : b_i;
      neg_d = a_i[31] ^ b_i[31];
      run_d = 1'b1;
      cnt_d = '0;
    end else if (run_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

/* sv/rpn_stack_evaluator_unit.sv */
// Top level of the RPN stack evaluator: token control, stack memory and divider.
`timescale 1ns / 1ps
// A request is taken when start_i is high and busy_o is low. A number, an ignored or
// aborting token and an end token without a valid value are handled while idle. An add,
// subtract or multiply passes through memory read, compute and write back, a divide by
// zero through read and compute, a divide also through the serial divider (one quotient
// bit per cycle). The result of an end token appears on result_o with done_o high for
// exactly one cycle, right after the request or, for a valid value read from the stack
// memory, after the read and compute states, and must be taken then; the receiver
// cannot stall the block. The stack memory has no reset and needs no clearing pass.
module rpn_stack_evaluator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rpn_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output rpn_pkg::res_t result_o
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SRead,
    SCalc,
    SDiv,
    SWrite
  } state_e;

  state_e              state_q;
  logic [CountWidth-1:0] count_q;
  logic [AddrWidth-1:0]  second_q;
  logic                has_second_q, flow_q, started_q;
  status_e             abort_q;
  op_e                 op_q;
  logic [31:0]         res_q;
  logic                busy_q, done_q;
  res_t                result_q;

  logic                we;
  logic [AddrWidth-1:0] waddr, top;
  logic [31:0]         wdata, rd_a, rd_b;
  logic                div_start, div_done;
  logic [31:0]         div_q;
  op_e                 op_in;
  logic                end_ok;

  assign op_in  = op_e'(req_i.op);
  assign top    = (count_q != '0) ? AddrWidth'(count_q - 1'b1) : '0;
  assign end_ok = abort_q == StOk && started_q && has_second_q && second_q == '0 &&
                  count_q == CountWidth'(1) && !flow_q;

  rpn_ram #(.Width(DataWidth), .Words(Depth)) u_ram (
    .clk_i,
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (second_q),
    .raddr_b_i (top),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign div_start = (state_q == SCalc) && (op_q == OpDiv) && (rd_b != '0);

  rpn_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .a_i     (rd_a),
    .b_i     (rd_b),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    we    = 1'b0;
    waddr = second_q;
    wdata = res_q;
    if (state_q == SIdle && start_i && abort_q == StOk && op_in == OpNum &&
        count_q < CountWidth'(Depth)) begin
      we    = 1'b1;
      waddr = AddrWidth'(count_q);
      wdata = req_i.value;
    end else if (state_q == SWrite) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      count_q      <= '0;
      second_q     <= '0;
      has_second_q <= 1'b0;
      flow_q       <= 1'b0;
      started_q    <= 1'b0;
      abort_q      <= StOk;
      op_q         <= OpNum;
      busy_q       <= 1'b0;
      done_q       <= 1'b0;
      res_q        <= '0;
      result_q     <= '0;
    end else begin
      unique case (state_q)
        SIdle: begin
          done_q <= start_i && op_in == OpEnd && !end_ok;
          if (start_i) begin
            op_q <= op_in;
            if (op_in == OpEnd) begin
              result_q.result_value <= '0;
              if (abort_q != StOk) begin
                result_q.status <= abort_q;
              end else if (!started_q) begin
                result_q.status <= StEmpty;
              end else if (!has_second_q || second_q != '0 || count_q == '0 ||
                           AddrWidth'(count_q - 1'b1) != second_q ||
                           count_q > CountWidth'(Depth)) begin
                result_q.status <= StMalformed;
              end else if (flow_q) begin
                result_q.status <= StFlow;
                flow_q          <= 1'b0;
              end else begin
                result_q.status <= StOk;
                state_q         <= SRead;
                busy_q          <= 1'b1;
              end
              if (!end_ok) begin
                count_q      <= '0;
                second_q     <= '0;
                has_second_q <= 1'b0;
                abort_q      <= StOk;
                started_q    <= 1'b0;
              end
            end else if (abort_q != StOk) begin
              // Tokens after an abort are dropped until the end token.
            end else if (!started_q) begin
              if (op_in == OpNum) begin
                count_q   <= count_q + 1'b1;
                started_q <= 1'b1;
              end else begin
                abort_q <= StBadFirst;
              end
            end else if (op_in == OpNum) begin
              has_second_q <= 1'b1;
              second_q     <= top;
              if (count_q >= CountWidth'(Depth)) begin
                flow_q <= 1'b1;
              end else begin
                count_q <= count_q + 1'b1;
              end
            end else if (has_second_q) begin
              if (op_in == OpAdd || op_in == OpSub || op_in == OpMul ||
                  op_in == OpDiv) begin
                state_q <= SRead;
                busy_q  <= 1'b1;
              end else begin
                abort_q <= StWrongOp;
              end
            end
          end
        end
        SRead: begin
          done_q  <= 1'b0;
          state_q <= SCalc;
        end
        SCalc: begin
          done_q <= (op_q == OpEnd);
          if (op_q == OpEnd) begin
            result_q.result_value <= rd_a;
            busy_q       <= 1'b0;
            state_q      <= SIdle;
            count_q      <= '0;
            second_q     <= '0;
            has_second_q <= 1'b0;
            abort_q      <= StOk;
            started_q    <= 1'b0;
          end else begin
            priority case (op_q)
              OpAdd: begin
                res_q   <= rd_a + rd_b;
                state_q <= SWrite;
              end
              OpSub: begin
                res_q   <= rd_a - rd_b;
                state_q <= SWrite;
              end
              OpMul: begin
                res_q   <= rd_a * rd_b;
                state_q <= SWrite;
              end
              default: begin
                if (rd_b == '0) begin
                  abort_q <= StDivZero;
                  busy_q  <= 1'b0;
                  state_q <= SIdle;
                end else begin
                  state_q <= SDiv;
                end
              end
            endcase
          end
        end
        SDiv: begin
          done_q <= 1'b0;
          if (div_done) begin
            res_q   <= div_q;
            state_q <= SWrite;
          end
        end
        SWrite: begin
          done_q <= 1'b0;
          if (count_q <= CountWidth'(1)) begin
            flow_q <= 1'b1;
          end else begin
            count_q <= count_q - 1'b1;
          end
          if (second_q != '0) begin
            second_q <= second_q - 1'b1;
          end
          busy_q  <= 1'b0;
          state_q <= SIdle;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountWidth'(Depth))
    else $error("Stack count beyond depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> busy_q)
    else $error("Block not busy while working.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q || $past(start_i))
    else $error("Result strobe without request.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == SDiv))
    else $error("Divider finished outside divide state.");

endmodule
